### sv/sha512_pkg.sv
// ============================================================================
// SHA-512 package
// Round constants, initial hash values and the round helper functions.
// ============================================================================
`default_nettype none

package sha512_pkg;

  localparam int unsigned BlockWords  = 16;
  localparam int unsigned HashWords   = 8;
  localparam int unsigned Rounds      = 80;
  localparam int unsigned LenStart    = 112;

  localparam logic [7:0]  PadByte     = 8'h80;

  localparam logic FuncAbsorb = 1'b0;
  localparam logic FuncFinish = 1'b1;

  typedef enum logic [5:0] {
    ST_IDLE  = 6'b000001,
    ST_LOAD  = 6'b000010,
    ST_ROUND = 6'b000100,
    ST_ADD   = 6'b001000,
    ST_PAD   = 6'b010000,
    ST_EMIT  = 6'b100000
  } state_t;

  localparam logic [63:0] RoundK [Rounds] = '{
    64'h428a2f98d728ae22, 64'h7137449123ef65cd, 64'hb5c0fbcfec4d3b2f, 64'he9b5dba58189dbbc,
    64'h3956c25bf348b538, 64'h59f111f1b605d019, 64'h923f82a4af194f9b, 64'hab1c5ed5da6d8118,
    64'hd807aa98a3030242, 64'h12835b0145706fbe, 64'h243185be4ee4b28c, 64'h550c7dc3d5ffb4e2,
    64'h72be5d74f27b896f, 64'h80deb1fe3b1696b1, 64'h9bdc06a725c71235, 64'hc19bf174cf692694,
    64'he49b69c19ef14ad2, 64'hefbe4786384f25e3, 64'h0fc19dc68b8cd5b5, 64'h240ca1cc77ac9c65,
    64'h2de92c6f592b0275, 64'h4a7484aa6ea6e483, 64'h5cb0a9dcbd41fbd4, 64'h76f988da831153b5,
    64'h983e5152ee66dfab, 64'ha831c66d2db43210, 64'hb00327c898fb213f, 64'hbf597fc7beef0ee4,
    64'hc6e00bf33da88fc2, 64'hd5a79147930aa725, 64'h06ca6351e003826f, 64'h142929670a0e6e70,
    64'h27b70a8546d22ffc, 64'h2e1b21385c26c926, 64'h4d2c6dfc5ac42aed, 64'h53380d139d95b3df,
    64'h650a73548baf63de, 64'h766a0abb3c77b2a8, 64'h81c2c92e47edaee6, 64'h92722c851482353b,
    64'ha2bfe8a14cf10364, 64'ha81a664bbc423001, 64'hc24b8b70d0f89791, 64'hc76c51a30654be30,
    64'hd192e819d6ef5218, 64'hd69906245565a910, 64'hf40e35855771202a, 64'h106aa07032bbd1b8,
    64'h19a4c116b8d2d0c8, 64'h1e376c085141ab53, 64'h2748774cdf8eeb99, 64'h34b0bcb5e19b48a8,
    64'h391c0cb3c5c95a63, 64'h4ed8aa4ae3418acb, 64'h5b9cca4f7763e373, 64'h682e6ff3d6b2b8a3,
    64'h748f82ee5defb2fc, 64'h78a5636f43172f60, 64'h84c87814a1f0ab72, 64'h8cc702081a6439ec,
    64'h90befffa23631e28, 64'ha4506cebde82bde9, 64'hbef9a3f7b2c67915, 64'hc67178f2e372532b,
    64'hca273eceea26619c, 64'hd186b8c721c0c207, 64'heada7dd6cde0eb1e, 64'hf57d4f7fee6ed178,
    64'h06f067aa72176fba, 64'h0a637dc5a2c898a6, 64'h113f9804bef90dae, 64'h1b710b35131c471b,
    64'h28db77f523047d84, 64'h32caab7b40c72493, 64'h3c9ebe0a15c9bebc, 64'h431d67c49c100d4c,
    64'h4cc5d4becb3e42b6, 64'h597f299cfc657e2a, 64'h5fcb6fab3ad6faec, 64'h6c44198c4a475817
  };

  localparam logic [63:0] InitHash [HashWords] = '{
    64'h6a09e667f3bcc908, 64'hbb67ae8584caa73b, 64'h3c6ef372fe94f82b, 64'ha54ff53a5f1d36f1,
    64'h510e527fade682d1, 64'h9b05688c2b3e6c1f, 64'h1f83d9abfb41bd6b, 64'h5be0cd19137e2179
  };

  function automatic logic [63:0] rotr(input logic [63:0] v, input int unsigned n);
    rotr = (v >> n) | (v << (64 - n));
  endfunction

  function automatic logic [63:0] big_sigma0(input logic [63:0] a);
    big_sigma0 = rotr(a, 28) ^ rotr(a, 34) ^ rotr(a, 39);
  endfunction

  function automatic logic [63:0] big_sigma1(input logic [63:0] e);
    big_sigma1 = rotr(e, 14) ^ rotr(e, 18) ^ rotr(e, 41);
  endfunction

  function automatic logic [63:0] small_sigma0(input logic [63:0] w);
    small_sigma0 = rotr(w, 1) ^ rotr(w, 8) ^ (w >> 7);
  endfunction

  function automatic logic [63:0] small_sigma1(input logic [63:0] w);
    small_sigma1 = rotr(w, 19) ^ rotr(w, 61) ^ (w >> 6);
  endfunction

endpackage

`default_nettype wire

### sv/sha512_hash_engine.sv
// ============================================================================
// SHA-512 hash engine
// Byte-serial SHA-512 with one shared round unit and an eight-word digest.
// ============================================================================
// An absorb word (in_func = 0) is taken while the engine is idle; the 128th
// byte of a block starts the compression, and in_ready stays low through it
// (a copy of the hash into the working variables, 80 rounds on the single
// round unit, and an add-back). A finish word (in_func = 1) pads the block,
// compresses once or twice (twice when 112 or more bytes of the block are
// used), then presents the eight digest words on out_*, h0 first, with
// out_last_word on the eighth. The output channel holds each word until
// taken; in_ready stays low until the last word is accepted. After a finish
// the engine starts a new message. The message schedule is a 16-word sliding
// window that is rewritten in place during the rounds; no new byte is taken
// while a block is being compressed.
`default_nettype none

module sha512_hash_engine import sha512_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic        in_func,
  input  wire logic [7:0]  in_data_byte,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [63:0]      out_digest_word,
  output logic [2:0]       out_word_index,
  output logic             out_last_word
);

  state_t      state_r;
  logic [63:0] hash_r   [HashWords];
  logic [63:0] blk_r    [BlockWords];
  logic [63:0] wv_r     [HashWords];
  logic [6:0]  pos_r;
  logic [63:0] len_lo_r;
  logic [63:0] len_hi_r;
  logic [6:0]  round_r;
  logic        final_r;   // finishing: after compress, pad again or emit
  logic        second_r;  // a length-only block is still to come
  logic [2:0]  widx_r;

  logic        in_fire;
  logic        out_fire;

  assign in_ready  = (state_r == ST_IDLE);
  assign in_fire   = in_valid && in_ready;
  assign out_valid = (state_r == ST_EMIT);
  assign out_fire  = out_valid && out_ready;

  assign out_digest_word = hash_r[widx_r];
  assign out_word_index  = widx_r;
  assign out_last_word   = (widx_r == 3'd7);

  // ---- Round unit: schedule word and one compression round ----
  logic [3:0]  ri;
  logic [63:0] w_new, w_cur, t1, t2;

  assign ri    = round_r[3:0];
  assign w_new = small_sigma1(blk_r[4'(ri - 4'd2)]) + blk_r[4'(ri - 4'd7)]
               + small_sigma0(blk_r[4'(ri - 4'd15)]) + blk_r[ri];
  assign w_cur = (round_r < 7'd16) ? blk_r[ri] : w_new;
  assign t1 = wv_r[7] + big_sigma1(wv_r[4])
            + ((wv_r[4] & wv_r[5]) ^ (~wv_r[4] & wv_r[6]))
            + RoundK[round_r] + w_cur;
  assign t2 = big_sigma0(wv_r[0])
            + ((wv_r[0] & wv_r[1]) ^ (wv_r[0] & wv_r[2]) ^ (wv_r[1] & wv_r[2]));

  // ---- Byte lane write for absorb ----
  logic [3:0]  bidx;
  logic [5:0]  bsh;
  assign bidx = pos_r[6:3];
  assign bsh  = 6'(7 - pos_r[2:0]) << 3;

  // ---- Padding: build the final block(s) combinationally from pos_r ----
  // Byte at pos_r becomes 0x80 (unless second block), rest of word zero,
  // following words zero; length goes into words 14/15 unless overflow.
  logic [63:0] pad_blk [BlockWords];
  logic        pad_two;
  always_comb begin
    pad_two = (pos_r >= 7'(LenStart));
    for (int i = 0; i < BlockWords; i++) begin
      if (second_r) begin
        pad_blk[i] = '0;
      end else if (4'(i) < bidx) begin
        pad_blk[i] = blk_r[i];
      end else if (4'(i) == bidx) begin
        pad_blk[i] = (pos_r[2:0] == 3'd0) ? (64'(PadByte) << bsh)
                   : ((blk_r[i] & ~(64'hffffffffffffffff >> (6'(pos_r[2:0]) << 3)))
                      | (64'(PadByte) << bsh));
      end else begin
        pad_blk[i] = '0;
      end
    end
    if (second_r || !pad_two) begin
      pad_blk[14] = len_hi_r;
      pad_blk[15] = len_lo_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      pos_r    <= '0;
      len_lo_r <= '0;
      len_hi_r <= '0;
      round_r  <= '0;
      final_r  <= 1'b0;
      second_r <= 1'b0;
      widx_r   <= '0;
      for (int i = 0; i < HashWords; i++) hash_r[i] <= InitHash[i];
    end else begin
      unique case (state_r)
        ST_IDLE: begin
          if (in_fire) begin
            if (in_func == FuncAbsorb) begin
              {len_hi_r, len_lo_r} <= {len_hi_r, len_lo_r} + 128'd8;
              if (pos_r[2:0] == 3'd0) blk_r[bidx] <= 64'(in_data_byte) << bsh;
              else blk_r[bidx] <= blk_r[bidx] | (64'(in_data_byte) << bsh);
              pos_r <= pos_r + 7'd1;
              if (pos_r == 7'd127) begin
                final_r <= 1'b0;
                state_r <= ST_LOAD;
              end
            end else begin
              final_r  <= 1'b1;
              second_r <= 1'b0;
              state_r  <= ST_PAD;
            end
          end
        end
        ST_PAD: begin
          // Load the padded block and queue a length-only block if needed.
          for (int i = 0; i < BlockWords; i++) blk_r[i] <= pad_blk[i];
          second_r <= !second_r && pad_two;
          state_r  <= ST_LOAD;
        end
        ST_LOAD: begin
          for (int i = 0; i < HashWords; i++) wv_r[i] <= hash_r[i];
          round_r <= '0;
          state_r <= ST_ROUND;
        end
        ST_ROUND: begin
          if (round_r >= 7'd16) blk_r[ri] <= w_new;
          // shift a..h down; e takes d + t1 instead of plain d
          for (int i = 1; i < HashWords; i++) begin
            if (i != 4) wv_r[i] <= wv_r[i-1];
          end
          wv_r[0] <= t1 + t2;
          wv_r[4] <= wv_r[3] + t1;
          if (round_r == 7'(Rounds - 1)) state_r <= ST_ADD;
          else round_r <= round_r + 7'd1;
        end
        ST_ADD: begin
          for (int i = 0; i < HashWords; i++) hash_r[i] <= hash_r[i] + wv_r[i];
          widx_r <= '0;
          if (!final_r) state_r <= ST_IDLE;
          else if (second_r) state_r <= ST_PAD;
          else state_r <= ST_EMIT;
        end
        ST_EMIT: begin
          if (out_fire) begin
            widx_r <= widx_r + 3'd1;
            if (widx_r == 3'd7) begin
              for (int i = 0; i < HashWords; i++) hash_r[i] <= InitHash[i];
              pos_r    <= '0;
              len_lo_r <= '0;
              len_hi_r <= '0;
              final_r  <= 1'b0;
              state_r  <= ST_IDLE;
            end
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  // ---- Assertions ----
  assert property (@(posedge clk) disable iff (!rst_n)
    $onehot(state_r))
    else $error("state not one-hot");

  assert property (@(posedge clk) disable iff (!rst_n)
    !(in_ready && out_valid))
    else $error("input ready while digest pending");

  assert property (@(posedge clk) disable iff (!rst_n)
    (out_fire && out_last_word) |=> (in_ready && pos_r == 7'd0))
    else $error("no restart after last digest word");

  assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_ROUND) |-> (round_r < 7'(Rounds)))
    else $error("round counter out of range");

endmodule

`default_nettype wire

### tb/sha512_digest_checker.sv
// ============================================================================
// SHA-512 digest checker
// Watches both channels of the hash engine, predicts the eight digest words
// of each finished message and compares them with the words that come out.
// ============================================================================
`timescale 1ns / 1ps

module sha512_digest_checker import sha512_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic        in_func,
  input  logic [7:0]  in_data_byte,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic [63:0] out_digest_word,
  input  logic [2:0]  out_word_index,
  input  logic        out_last_word,
  output int          fail_count,
  output int          pending_words
);

  typedef struct packed {
    logic [63:0] digest_word;
    logic [2:0]  word_index;
    logic        last_word;
  } digest_out_t;

  logic [63:0]  hash_state [HashWords];
  logic [63:0]  msg_block [BlockWords];
  logic [6:0]   fill_pos;
  logic [127:0] msg_bits;
  digest_out_t  digest_queue [$];

  assign pending_words = digest_queue.size();

  function automatic logic [63:0] ror64(logic [63:0] v, int n);
    return (v >> n) | (v << (64 - n));
  endfunction

  task automatic restart_message();
    for (int i = 0; i < HashWords; i++) hash_state[i] = InitHash[i];
    fill_pos = '0;
    msg_bits = '0;
  endtask

  task automatic compress_block();
    logic [63:0] w [Rounds];
    logic [63:0] v [8];
    logic [63:0] s0, s1, t1, t2;
    for (int t = 0; t < 16; t++) w[t] = msg_block[t];
    for (int t = 16; t < Rounds; t++) begin
      s1 = ror64(w[t-2], 19) ^ ror64(w[t-2], 61) ^ (w[t-2] >> 6);
      s0 = ror64(w[t-15], 1) ^ ror64(w[t-15], 8) ^ (w[t-15] >> 7);
      w[t] = s1 + w[t-7] + s0 + w[t-16];
    end
    for (int i = 0; i < 8; i++) v[i] = hash_state[i];
    for (int t = 0; t < Rounds; t++) begin
      t1 = v[7] + (ror64(v[4], 14) ^ ror64(v[4], 18) ^ ror64(v[4], 41))
         + ((v[4] & v[5]) ^ (~v[4] & v[6])) + RoundK[t] + w[t];
      t2 = (ror64(v[0], 28) ^ ror64(v[0], 34) ^ ror64(v[0], 39))
         + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
      for (int i = 7; i > 0; i--) v[i] = v[i-1];
      v[0] = t1 + t2;
      v[4] = v[4] + t1;
    end
    for (int i = 0; i < 8; i++) hash_state[i] = hash_state[i] + v[i];
  endtask

  task automatic place_byte(int pos, logic [7:0] b);
    msg_block[pos / 8][63 - 8 * (pos % 8) -: 8] = b;
  endtask

  task automatic absorb_word(logic func, logic [7:0] b);
    int pos;
    digest_out_t d;
    if (func == FuncAbsorb) begin
      msg_bits = msg_bits + 128'd8;
      place_byte(fill_pos, b);
      fill_pos = fill_pos + 7'd1;
      if (fill_pos == 0) compress_block();
      return;
    end
    // pad: marker byte, zeros, and the 128-bit length in the last two words
    pos = fill_pos;
    place_byte(pos, PadByte);
    pos++;
    if (pos > LenStart) begin
      while (pos < 128) begin place_byte(pos, 8'h00); pos++; end
      compress_block();
      pos = 0;
    end
    while (pos < LenStart) begin place_byte(pos, 8'h00); pos++; end
    msg_block[14] = msg_bits[127:64];
    msg_block[15] = msg_bits[63:0];
    compress_block();
    for (int i = 0; i < HashWords; i++) begin
      d.digest_word = hash_state[i];
      d.word_index  = 3'(i);
      d.last_word   = (i == 7);
      digest_queue.push_back(d);
    end
    restart_message();
  endtask

  initial begin
    fail_count = 0;
    restart_message();
  end

  always @(posedge clk) begin
    digest_out_t exp_d;
    if (rst_n) begin
      if (in_valid && in_ready) absorb_word(in_func, in_data_byte);
      if (out_valid && out_ready) begin
        if (digest_queue.size() == 0) begin
          $error("unexpected digest word %h", out_digest_word);
          fail_count++;
        end else begin
          exp_d = digest_queue.pop_front();
          if (out_digest_word !== exp_d.digest_word) begin
            $error("digest_word expected %h got %h", exp_d.digest_word, out_digest_word);
            fail_count++;
          end
          if (out_word_index !== exp_d.word_index) begin
            $error("word_index expected %0d got %0d", exp_d.word_index, out_word_index);
            fail_count++;
          end
          if (out_last_word !== exp_d.last_word) begin
            $error("last_word expected %0d got %0d", exp_d.last_word, out_last_word);
            fail_count++;
          end
        end
      end
    end
  end

endmodule

### tb/sha512_hash_engine_tb.sv
// ============================================================================
// SHA-512 hash engine testbench
// Drives byte messages and finish words with random gaps and output stalls;
// the checker predicts every digest and the top gives the verdict.
// ============================================================================
`timescale 1ns / 1ps

module sha512_hash_engine_tb import sha512_pkg::*;;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic        in_func = FuncAbsorb;
  logic [7:0]  in_data_byte = 8'h00;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [63:0] out_digest_word;
  logic [2:0]  out_word_index;
  logic        out_last_word;
  int          fail_count;
  int          pending_words;
  int          cycle_count = 0;
  int          tail_wait;

  localparam int CycleLimit = 2_000_000;
  localparam int ItemTarget = 400;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  sha512_hash_engine u_dut (
    .clk, .rst_n, .in_valid, .in_ready, .in_func, .in_data_byte,
    .out_valid, .out_ready, .out_digest_word, .out_word_index, .out_last_word
  );

  sha512_digest_checker u_checker (
    .clk, .rst_n, .in_valid, .in_ready, .in_func, .in_data_byte,
    .out_valid, .out_ready, .out_digest_word, .out_word_index, .out_last_word,
    .fail_count, .pending_words
  );

  // Mostly short gaps, now and then a long one.
  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  // Drive one word at the falling edge and hold it until it is taken.
  // Valid drops only when a gap follows, so back-to-back words keep it high.
  task automatic send_word(logic func, logic [7:0] b);
    int gap;
    gap = gap_len();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid     <= 1'b1;
    in_func      <= func;
    in_data_byte <= b;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
  endtask

  task automatic send_message(int len, int fill_mode);
    logic [7:0] b;
    for (int i = 0; i < len; i++) begin
      case (fill_mode)
        0: b = 8'h00;
        1: b = 8'hff;
        default: b = 8'($urandom);
      endcase
      send_word(FuncAbsorb, b);
    end
    // finish carries a junk byte that must be ignored
    send_word(FuncFinish, 8'($urandom));
  endtask

  // Output stall pattern: bursts of ready with random gaps, one calm stretch.
  always @(negedge clk) begin
    if (cycle_count < 20000 || cycle_count > 40000)
      out_ready <= ($urandom_range(0, 99) < 60);
    else
      out_ready <= 1'b1;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("FAIL");
      $finish;
    end
  end

  initial begin
    int items;
    int len;
    int dir_len [6];
    int dir_mode [6];
    dir_len  = '{0, 1, 1, 111, 112, 0};
    dir_mode = '{2, 0, 1, 2, 1, 2};
    repeat (3) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed: empty message, single bytes at the extremes, and lengths
    // around the padding boundary.
    items = 0;
    for (int i = 0; i < 6; i++) begin
      send_message(dir_len[i], dir_mode[i]);
      items += dir_len[i] + 1;
    end

    // Random messages: mostly short, some crossing block boundaries.
    while (items < ItemTarget) begin
      if ($urandom_range(0, 9) < 7) len = $urandom_range(0, 30);
      else len = $urandom_range(100, 260);
      if (len > ItemTarget - items - 1) len = ItemTarget - items - 1;
      send_message(len, ($urandom_range(0, 9) == 0) ? $urandom_range(0, 1) : 2);
      items += len + 1;
    end
    in_valid <= 1'b0;

    while (pending_words != 0) @(negedge clk);
    tail_wait = 200;
    while (tail_wait > 0) begin
      @(negedge clk);
      tail_wait--;
    end
    if (fail_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
